/* hw/rtl/fra_pkg.sv */
// ----------------------------------------------------------------------------
// Fraction add and reduce: shared package
// Sequencer states, phase codes and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int SUM_NUM_W = 34;
  localparam int SUM_DEN_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,
    ST_GSHIFT,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_SUBR,
    ST_G2,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    PH_G1,
    PH_KA,
    PH_KB,
    PH_LCM,
    PH_TA,
    PH_TB,
    PH_G2,
    PH_RN,
    PH_RD
  } phase_t;

endpackage

/* hw/rtl/fra_alu.sv */
// ----------------------------------------------------------------------------
// Fraction add and reduce: shared add/subtract unit
// One adder that serves the gcd subtractions and every division, multiplication and sum step.
// ----------------------------------------------------------------------------
module fra_alu #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] res,
  output logic             cout
);

  logic [WIDTH-1:0] b_op;

  assign b_op = sub ? ~b : b;

  // With sub set, cout high means a is not less than b.
  assign {cout, res} = {1'b0, a} + {1'b0, b_op} + {{WIDTH{1'b0}}, sub};

endmodule

/* hw/rtl/fra_core.sv */
// ----------------------------------------------------------------------------
// Fraction add and reduce: sequencer and datapath
// Runs binary gcd, shift-subtract division and shift-add multiplication
// through the shared add/subtract unit, one step per cycle.
// ----------------------------------------------------------------------------
module fra_core #(
  parameter int IN_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [IN_WIDTH-1:0]           num_a,
  input  logic        [IN_WIDTH-1:0]           den_a,
  input  logic signed [IN_WIDTH-1:0]           num_b,
  input  logic        [IN_WIDTH-1:0]           den_b,
  output logic                                 ready,
  output logic                                 done,
  input  logic                                 ack,
  output logic signed [fra_pkg::SUM_NUM_W-1:0] res_num,
  output logic        [fra_pkg::SUM_DEN_W-1:0] res_den,
  output logic                                 res_err
);

  import fra_pkg::*;

  localparam int IW = IN_WIDTH;
  localparam int DW = 2 * IN_WIDTH;
  localparam int AW = DW + 1;
  localparam int CW = $clog2(DW + 1);

  state_t state, state_next;
  phase_t phase;

  logic [DW-1:0] x, y, rem, quo, acc, mcand, g, lcmv, ta, tb, mag;
  logic [IW-1:0] mplier, ma, mb, da, db, ka, kb;
  logic [CW-1:0] cnt, k;
  logic          na, nb, neg;

  logic [IW-1:0] a_raw, b_raw, ma_in, mb_in;
  logic          den_bad;

  logic [AW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_cout;

  logic [SUM_NUM_W-1:0] rn_ext;

  assign a_raw   = num_a;
  assign b_raw   = num_b;
  assign ma_in   = a_raw[IW-1] ? (~a_raw + 1'b1) : a_raw;
  assign mb_in   = b_raw[IW-1] ? (~b_raw + 1'b1) : b_raw;
  assign den_bad = (den_a == '0) || (den_b == '0);
  assign rn_ext  = SUM_NUM_W'(mag);

  assign ready = (state == ST_IDLE);
  assign done  = (state == ST_DONE);

  fra_alu #(.WIDTH(AW)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .res  (alu_res),
    .cout (alu_cout)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_GCD: begin
        alu_a   = {1'b0, x};
        alu_b   = {1'b0, y};
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {rem, quo[DW-1]};
        alu_b   = {1'b0, y};
        alu_sub = 1'b1;
      end
      ST_MUL: begin
        alu_a = {1'b0, acc};
        alu_b = {1'b0, mcand};
      end
      ST_ADD: begin
        alu_a   = {1'b0, ta};
        alu_b   = {1'b0, tb};
        alu_sub = na ^ nb;
      end
      ST_SUBR: begin
        alu_a   = {1'b0, tb};
        alu_b   = {1'b0, ta};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = den_bad ? ST_DONE : ST_GCD;
        end
      end
      ST_GCD: begin
        if ((x == '0) || (y == '0)) begin
          state_next = ST_GSHIFT;
        end
      end
      ST_GSHIFT: begin
        if (k == '0) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          if (phase == PH_KB) begin
            state_next = ST_MUL;
          end else if (phase == PH_RD) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        if ((cnt == '0) && (phase == PH_TB)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = ((na == nb) || alu_cout) ? ST_G2 : ST_SUBR;
      end
      ST_SUBR: begin
        state_next = ST_G2;
      end
      ST_G2: begin
        state_next = ST_GCD;
      end
      ST_DONE: begin
        if (ack) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_G1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            ma      <= ma_in;
            mb      <= mb_in;
            na      <= a_raw[IW-1];
            nb      <= b_raw[IW-1];
            da      <= den_a;
            db      <= den_b;
            x       <= {{IW{1'b0}}, den_a};
            y       <= {{IW{1'b0}}, den_b};
            k       <= '0;
            phase   <= PH_G1;
            res_num <= '0;
            res_den <= '0;
            res_err <= den_bad;
          end
        end
        ST_GCD: begin
          if (x == '0) begin
            x <= y;
          end else if (y == '0) begin
            x <= x;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (alu_cout) begin
            x <= alu_res[DW-1:0];
          end else begin
            x <= y;
            y <= x;
          end
        end
        ST_GSHIFT: begin
          if (k == '0) begin
            g   <= x;
            y   <= x;
            rem <= '0;
            if (phase == PH_G1) begin
              quo   <= {db, {IW{1'b0}}};
              cnt   <= CW'(IW);
              phase <= PH_KA;
            end else begin
              quo   <= mag;
              cnt   <= CW'(DW);
              phase <= PH_RN;
            end
          end else begin
            x <= x << 1;
            k <= k - 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            rem <= '0;
            y   <= g;
            case (phase)
              PH_KA: begin
                ka    <= quo[IW-1:0];
                quo   <= {da, {IW{1'b0}}};
                cnt   <= CW'(IW);
                phase <= PH_KB;
              end
              PH_KB: begin
                kb     <= quo[IW-1:0];
                acc    <= '0;
                mcand  <= {{IW{1'b0}}, db};
                mplier <= quo[IW-1:0];
                cnt    <= CW'(IW);
                phase  <= PH_LCM;
              end
              PH_RN: begin
                mag   <= quo;
                quo   <= lcmv;
                cnt   <= CW'(DW);
                phase <= PH_RD;
              end
              default: begin
                res_den <= SUM_DEN_W'(quo);
                res_num <= neg ? (~rn_ext + 1'b1) : rn_ext;
                res_err <= 1'b0;
              end
            endcase
          end else begin
            rem <= alu_cout ? alu_res[DW-1:0] : alu_a[DW-1:0];
            quo <= {quo[DW-2:0], alu_cout};
            cnt <= cnt - 1'b1;
          end
        end
        ST_MUL: begin
          if (cnt == '0) begin
            acc <= '0;
            cnt <= CW'(IW);
            case (phase)
              PH_LCM: begin
                lcmv   <= acc;
                mcand  <= {{IW{1'b0}}, ma};
                mplier <= ka;
                phase  <= PH_TA;
              end
              PH_TA: begin
                ta     <= acc;
                mcand  <= {{IW{1'b0}}, mb};
                mplier <= kb;
                phase  <= PH_TB;
              end
              default: begin
                tb <= acc;
              end
            endcase
          end else begin
            if (mplier[0]) begin
              acc <= alu_res[DW-1:0];
            end
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt - 1'b1;
          end
        end
        ST_ADD: begin
          if ((na == nb) || alu_cout) begin
            mag <= alu_res[DW-1:0];
            neg <= na;
          end
        end
        ST_SUBR: begin
          mag <= alu_res[DW-1:0];
          neg <= nb;
        end
        ST_G2: begin
          if (mag == '0) begin
            neg <= 1'b0;
          end
          x     <= mag;
          y     <= lcmv;
          k     <= '0;
          phase <= PH_G2;
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/fraction_add_reduce.sv */
// The two binary gcd loops and their shift-back take a data-dependent time. A request with a
// zero denominator goes from idle straight to done and skips the arithmetic. One add/subtract
// unit does all the arithmetic for one request at a time, so a new request is taken only once
// the last one has left the sequencer for the result register. Reset is synchronous and active
// high; it returns the sequencer to idle and clears the result valid flag.
// ----------------------------------------------------------------------------
// Fraction add and reduce: top level
// Adds two fractions and returns the sum in lowest terms, flagging a zero
// denominator, with a result register between the sequencer and the output.
// ----------------------------------------------------------------------------
module fraction_add_reduce #(
  parameter int IN_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic signed [IN_WIDTH-1:0]           num_a,
  input  logic        [IN_WIDTH-1:0]           den_a,
  input  logic signed [IN_WIDTH-1:0]           num_b,
  input  logic        [IN_WIDTH-1:0]           den_b,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic signed [fra_pkg::SUM_NUM_W-1:0] sum_num,
  output logic        [fra_pkg::SUM_DEN_W-1:0] sum_den,
  output logic                                 den_zero
);

  import fra_pkg::*;

  logic                        core_ready, core_done, load;
  logic signed [SUM_NUM_W-1:0] core_num;
  logic        [SUM_DEN_W-1:0] core_den;
  logic                        core_err;

  assign req_stall = !core_ready;
  assign load      = core_done && (!res_valid || !res_stall);

  fra_core #(.IN_WIDTH(IN_WIDTH)) u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (req_valid && core_ready),
    .num_a   (num_a),
    .den_a   (den_a),
    .num_b   (num_b),
    .den_b   (den_b),
    .ready   (core_ready),
    .done    (core_done),
    .ack     (load),
    .res_num (core_num),
    .res_den (core_den),
    .res_err (core_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_num  <= core_num;
      sum_den  <= core_den;
      den_zero <= core_err;
    end
  end

endmodule

/* hw/rtl/fra_chk.sv */
// ----------------------------------------------------------------------------
// Fraction add and reduce: port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module fra_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_valid,
  input logic                                 req_stall,
  input logic                                 res_valid,
  input logic                                 res_stall,
  input logic signed [fra_pkg::SUM_NUM_W-1:0] sum_num,
  input logic        [fra_pkg::SUM_DEN_W-1:0] sum_den,
  input logic                                 den_zero
);

  import fra_pkg::*;

  // A stalled result must be held unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(sum_num) && $stable(sum_den)
      && $stable(den_zero))
    else $error("stalled result changed");

  // Once a request is taken the block is busy in the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("block took a request without going busy");

  // A zero denominator gives a zero fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && den_zero |-> (sum_num == '0) && (sum_den == '0))
    else $error("error result is not zero");

  // A zero sum is always reduced to a denominator of one.
  a_zero_sum: assert property (@(posedge clk) disable iff (rst)
    res_valid && !den_zero && (sum_num == '0) |-> (sum_den == SUM_DEN_W'(1)))
    else $error("zero sum not reduced to a denominator of one");

endmodule

bind fraction_add_reduce fra_chk u_fra_chk (.*);

/* verif/fraction_sum_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction add and reduce: result checker
// Watches the request and result channels, works out the reduced sum for every
// accepted request and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module fraction_sum_checker #(
  parameter int IN_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  input  logic                                 req_stall,
  input  logic signed [IN_WIDTH-1:0]           num_a,
  input  logic        [IN_WIDTH-1:0]           den_a,
  input  logic signed [IN_WIDTH-1:0]           num_b,
  input  logic        [IN_WIDTH-1:0]           den_b,
  input  logic                                 res_valid,
  input  logic                                 res_stall,
  input  logic signed [fra_pkg::SUM_NUM_W-1:0] sum_num,
  input  logic        [fra_pkg::SUM_DEN_W-1:0] sum_den,
  input  logic                                 den_zero,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   n_sums,
  output int                                   n_den_zero,
  output int                                   n_cancelled
);

  import fra_pkg::*;

  typedef struct packed {
    logic signed [SUM_NUM_W-1:0] num;
    logic        [SUM_DEN_W-1:0] den;
    logic                        dz;
  } sum_frac_t;

  sum_frac_t expected_sums[$];

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic sum_frac_t add_fractions(logic signed [IN_WIDTH-1:0] na,
                                              logic [IN_WIDTH-1:0] da,
                                              logic signed [IN_WIDTH-1:0] nb,
                                              logic [IN_WIDTH-1:0] db);
    sum_frac_t s;
    longint sa, sb;
    longint unsigned ma, mb, ua, ub, g1, ka, kb, lcm, ta, tb, mag, g2, rn, rd, sn;
    logic nega, negb, neg;
    s = '0;
    if (da == 0 || db == 0) begin
      s.dz = 1'b1;
      return s;
    end
    sa = 64'(na);
    sb = 64'(nb);
    nega = sa < 0;
    negb = sb < 0;
    ma = nega ? -sa : sa;
    mb = negb ? -sb : sb;
    ua = 64'(da);
    ub = 64'(db);
    g1 = euclid_gcd(ua, ub);
    ka = ub / g1;
    kb = ua / g1;
    lcm = kb * ub;
    ta = ma * ka;
    tb = mb * kb;
    if (nega == negb) begin
      mag = ta + tb;
      neg = nega;
    end else if (ta >= tb) begin
      mag = ta - tb;
      neg = nega;
    end else begin
      mag = tb - ta;
      neg = negb;
    end
    if (mag == 0) neg = 1'b0;
    g2 = euclid_gcd(mag, lcm);
    rn = mag / g2;
    rd = lcm / g2;
    sn = neg ? -rn : rn;
    s.num = sn[SUM_NUM_W-1:0];
    s.den = rd[SUM_DEN_W-1:0];
    return s;
  endfunction

  always @(posedge clk) begin
    sum_frac_t want;
    if (rst) begin
      expected_sums.delete();
    end else begin
      if (req_valid && !req_stall) begin
        expected_sums.push_back(add_fractions(num_a, den_a, num_b, den_b));
      end
      if (res_valid && !res_stall) begin
        if (expected_sums.size() == 0) begin
          $error("result %0d/%0d with no request outstanding", sum_num, sum_den);
          fail_count++;
        end else begin
          want = expected_sums.pop_front();
          n_sums++;
          if (want.dz) n_den_zero++;
          else if (want.num == 0) n_cancelled++;
          if (sum_num !== want.num) begin
            $error("sum_num: expected %0d, got %0d", want.num, sum_num);
            fail_count++;
          end
          if (sum_den !== want.den) begin
            $error("sum_den: expected %0d, got %0d", want.den, sum_den);
            fail_count++;
          end
          if (den_zero !== want.dz) begin
            $error("den_zero: expected %0d, got %0d", want.dz, den_zero);
            fail_count++;
          end
        end
      end
    end
    pending = expected_sums.size();
  end

endmodule

/* verif/fraction_add_reduce_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction add and reduce: testbench
// Sends directed corner requests and then random ones with random gaps and
// back-pressure, including one long hold-off of the results, and reports the
// checker's verdict once every expected sum has come back.
// ----------------------------------------------------------------------------
module fraction_add_reduce_tb;
  import fra_pkg::*;

  localparam int IN_WIDTH    = 16;
  localparam int N_RANDOM    = 800;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 1500;
  localparam int QUIET_FROM  = 400;
  localparam int QUIET_TO    = 550;
  localparam int DRAIN       = 300;
  localparam int STUCK_LIMIT = 20000;

  logic                        clk;
  logic                        rst;
  logic                        req_valid;
  logic                        req_stall;
  logic signed [IN_WIDTH-1:0]  num_a;
  logic        [IN_WIDTH-1:0]  den_a;
  logic signed [IN_WIDTH-1:0]  num_b;
  logic        [IN_WIDTH-1:0]  den_b;
  logic                        res_valid;
  logic                        res_stall;
  logic signed [SUM_NUM_W-1:0] sum_num;
  logic        [SUM_DEN_W-1:0] sum_den;
  logic                        den_zero;

  int   fail_count, pending, n_sums, n_den_zero, n_cancelled;
  int   n_sent;
  int   stuck_cycles;
  logic hold_done;
  logic no_idle;

  assign no_idle = n_sent >= QUIET_FROM && n_sent < QUIET_TO;

  fraction_add_reduce #(
    .IN_WIDTH(IN_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .num_a    (num_a),
    .den_a    (den_a),
    .num_b    (num_b),
    .den_b    (den_b),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .sum_num  (sum_num),
    .sum_den  (sum_den),
    .den_zero (den_zero)
  );

  fraction_sum_checker #(
    .IN_WIDTH(IN_WIDTH)
  ) u_sum_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .num_a      (num_a),
    .den_a      (den_a),
    .num_b      (num_b),
    .den_b      (den_b),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .sum_num    (sum_num),
    .sum_den    (sum_den),
    .den_zero   (den_zero),
    .fail_count (fail_count),
    .pending    (pending),
    .n_sums     (n_sums),
    .n_den_zero (n_den_zero),
    .n_cancelled(n_cancelled)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("fraction_add_reduce_tb: done, errors");
        $finish;
      end
    end
  end

  // The result side stalls at random outside the quiet window, except for one long hold-off that lets
  // the block fill up and push back on the requests.
  initial begin
    res_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_sent >= HOLD_AT) begin
        res_stall <= 1'b1;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        res_stall <= !no_idle && ($urandom_range(99) < 27);
      end
    end
  end

  task automatic send_request(input logic signed [IN_WIDTH-1:0] na,
                              input logic [IN_WIDTH-1:0] da,
                              input logic signed [IN_WIDTH-1:0] nb,
                              input logic [IN_WIDTH-1:0] db);
    if (!no_idle && $urandom_range(99) < 27) begin
      req_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 27) @(negedge clk);
    end
    req_valid <= 1'b1;
    num_a     <= na;
    den_a     <= da;
    num_b     <= nb;
    den_b     <= db;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  initial begin
    logic signed [IN_WIDTH-1:0] na, nb;
    logic        [IN_WIDTH-1:0] da, db;
    int kind;
    rst       = 1'b1;
    req_valid = 1'b0;
    num_a     = '0;
    den_a     = '0;
    num_b     = '0;
    den_b     = '0;
    n_sent    = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send_request(1, 2, 1, 3);
    send_request(1, 2, -1, 2);
    send_request(-32768, 1, -32768, 1);
    send_request(32767, 1, 32767, 1);
    send_request(32767, 65535, 32767, 65534);
    send_request(-32768, 65535, -32768, 65534);
    send_request(-32768, 65534, 32767, 65535);
    send_request(0, 5, 0, 7);
    send_request(3, 0, 1, 2);
    send_request(1, 2, 3, 0);
    send_request(0, 0, 0, 0);
    send_request(-32768, 0, 32767, 65535);
    send_request(5, 65535, -5, 65535);
    send_request(6, 4, 2, 4);
    send_request(-1, 1, 0, 65535);
    send_request(32767, 32768, -32768, 32768);
    send_request(1, 65535, 1, 1);
    send_request(-7, 6, 5, 4);
    send_request(12345, 30000, -6789, 45000);
    send_request(0, 1, 0, 1);

    repeat (N_RANDOM) begin
      kind = $urandom_range(99);
      na = IN_WIDTH'($urandom);
      nb = IN_WIDTH'($urandom);
      da = IN_WIDTH'($urandom);
      db = IN_WIDTH'($urandom);
      if (kind < 10) begin
        case ($urandom_range(2))
          0: da = '0;
          1: db = '0;
          default: begin
            da = '0;
            db = '0;
          end
        endcase
      end else if (kind < 45) begin
        na = IN_WIDTH'($urandom_range(40) - 20);
        nb = IN_WIDTH'($urandom_range(40) - 20);
        da = IN_WIDTH'($urandom_range(12, 1));
        db = IN_WIDTH'($urandom_range(12, 1));
      end else if (kind < 55) begin
        if (da == 0) da = 1;
        db = da;
        nb = -na;
      end else begin
        if (da == 0) da = IN_WIDTH'($urandom_range(65535, 1));
        if (db == 0) db = IN_WIDTH'($urandom_range(65535, 1));
      end
      send_request(na, da, nb, db);
    end
    req_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("%0d requests sent, %0d sums checked: %0d with a zero denominator, %0d cancelled",
             n_sent, n_sums, n_den_zero, n_cancelled);
    $display("results were held off once for %0d cycles with requests still on offer",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("fraction_add_reduce_tb: done, clean");
    end else begin
      $display("fraction_add_reduce_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fra_pkg.sv
hw/rtl/fra_alu.sv
hw/rtl/fra_core.sv
hw/rtl/fraction_add_reduce.sv
hw/rtl/fra_chk.sv
verif/fraction_sum_checker.sv
verif/fraction_add_reduce_tb.sv
